// File: src/sust_pkg.sv
// Shared types and constants for the sorted unique set table.
// Used by sust_cell and sorted_unique_set_table; depends on nothing.
`default_nettype none

package sust_pkg;

  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_OUT_W  = 9;
  localparam int unsigned CAPACITY_DEF = 256;
  // eq flags are OR-reduced in registered groups of this size
  localparam int unsigned GROUP_SIZE   = 16;

  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                      cmp_en;
    logic                      ins_en;
    logic                      del_en;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: src/sorted_unique_set_table.sv
// Top level of the sorted unique set table: control sequencer, result register
// and the chain of sust_cell slots. Depends on sust_pkg and sust_cell.
`default_nettype none

// Keeps up to CAPACITY distinct signed 32-bit values in ascending order, one
// per cell of a chain. Each item searches, inserts or deletes one value and
// yields one result with the found flag, a status and the count afterwards.
// The result is registered in three steps after the item is accepted: parallel
// compare in all cells, a registered OR of the match flags in groups of
// GROUP_SIZE, then the decision and the one-step shift of the chain. The input
// stays stalled until the sequencer is idle again, so no item is taken before
// the last result is registered. While the output register holds an unaccepted
// result, the next item waits in its decision step. No clearing pass after reset.
module sorted_unique_set_table #(
  parameter int unsigned CAPACITY = sust_pkg::CAPACITY_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [sust_pkg::ACTION_W-1:0]           action_i,
  input  logic signed [sust_pkg::VALUE_W-1:0]     value_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    found_o,
  output logic [sust_pkg::STATUS_W-1:0]           status_o,
  output logic [sust_pkg::COUNT_OUT_W-1:0]        entry_count_o
);

  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
  localparam int unsigned NUM_GROUPS = (CAPACITY + sust_pkg::GROUP_SIZE - 1) /
                                       sust_pkg::GROUP_SIZE;
  localparam int unsigned PAD_W      = NUM_GROUPS * sust_pkg::GROUP_SIZE;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_RED, S_APPLY} state_e;

  state_e                                state_q;
  logic [sust_pkg::ACTION_W-1:0]         action_q;
  logic signed [sust_pkg::VALUE_W-1:0]   value_q;
  logic [CNT_W-1:0]                      count_q;
  logic [CNT_W-1:0]                      count_d;
  logic [NUM_GROUPS-1:0]                 group_or_q;
  logic [NUM_GROUPS-1:0]                 group_or_d;
  logic                                  out_valid_q;
  logic                                  found_q;
  logic [sust_pkg::STATUS_W-1:0]         status_q;
  logic [sust_pkg::STATUS_W-1:0]         status_d;
  logic [CNT_W-1:0]                      out_count_q;

  logic                                  in_accept;
  logic                                  out_free;
  logic                                  apply;
  logic                                  present;
  logic                                  full;
  sust_pkg::cell_cmd_t                   cmd;

  logic signed [sust_pkg::VALUE_W-1:0]   val_w [CAPACITY];
  logic [CAPACITY-1:0]                   lt_w;
  logic [CAPACITY-1:0]                   eq_w;
  logic [PAD_W-1:0]                      eq_pad;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign apply      = (state_q == S_APPLY) && out_free;

  assign present = |group_or_q;
  assign full    = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    cmd.cmp_en = (state_q == S_CMP);
    cmd.ins_en = apply && (action_q == sust_pkg::ACT_INSERT) && !present && !full;
    cmd.del_en = apply && (action_q == sust_pkg::ACT_DELETE) && present;
    cmd.value  = value_q;
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins_en) begin
      count_d = count_q + 1'b1;
    end else if (cmd.del_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    case (action_q)
      sust_pkg::ACT_INSERT: begin
        if (present) begin
          status_d = sust_pkg::ST_DUP;
        end else if (full) begin
          status_d = sust_pkg::ST_FULL;
        end else begin
          status_d = sust_pkg::ST_DONE;
        end
      end
      default: begin
        status_d = present ? sust_pkg::ST_DONE : sust_pkg::ST_ABSENT;
      end
    endcase
  end

  // match flags reduced in groups; at most one cell can match
  assign eq_pad = PAD_W'(eq_w);
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    assign group_or_d[g] = |eq_pad[g*sust_pkg::GROUP_SIZE +: sust_pkg::GROUP_SIZE];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                                prev_lt;
    logic signed [sust_pkg::VALUE_W-1:0] prev_val;
    logic signed [sust_pkg::VALUE_W-1:0] next_val;

    if (i == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign prev_val = value_q;
    end else begin : g_mid
      assign prev_lt  = lt_w[i-1];
      assign prev_val = val_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_val = val_w[i];
    end else begin : g_inner
      assign next_val = val_w[i+1];
    end

    sust_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .count_i    (count_q),
      .prev_lt_i  (prev_lt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .val_o      (val_w[i]),
      .lt_o       (lt_w[i]),
      .eq_o       (eq_w[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      status_q    <= sust_pkg::ST_DONE;
      out_count_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_RED;
        end
        S_RED: begin
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      count_q <= count_d;
      if (apply) begin
        out_valid_q <= 1'b1;
        found_q     <= present;
        status_q    <= status_d;
        out_count_q <= count_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q <= action_i;
      value_q  <= value_i;
    end
    if (state_q == S_RED) begin
      group_or_q <= group_or_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign status_o      = status_q;
  assign entry_count_o = sust_pkg::COUNT_OUT_W'(out_count_q);

endmodule

`default_nettype wire

// File: src/sust_cell.sv
// One slot of the sorted chain: holds a value, compares it with the broadcast
// key, and shifts from its left or right neighbor on insert or delete.
// Depends on sust_pkg.
`default_nettype none

module sust_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 9
) (
  input  logic                                 clk_i,
  input  sust_pkg::cell_cmd_t                  cmd_i,
  input  logic [CNT_W-1:0]                     count_i,
  input  logic                                 prev_lt_i,
  input  logic signed [sust_pkg::VALUE_W-1:0]  prev_val_i,
  input  logic signed [sust_pkg::VALUE_W-1:0]  next_val_i,
  output logic signed [sust_pkg::VALUE_W-1:0]  val_o,
  output logic                                 lt_o,
  output logic                                 eq_o
);

  logic signed [sust_pkg::VALUE_W-1:0] val_q;
  logic                                lt_q;
  logic                                eq_q;
  logic                                occupied;

  assign occupied = count_i > CNT_W'(INDEX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      lt_q <= occupied && (val_q < cmd_i.value);
      eq_q <= occupied && (val_q == cmd_i.value);
    end
    // lt flags form a prefix; the first cell not below the key is the split point
    if (cmd_i.ins_en && !lt_q) begin
      val_q <= prev_lt_i ? cmd_i.value : prev_val_i;
    end else if (cmd_i.del_en && !lt_q) begin
      val_q <= next_val_i;
    end
  end

  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

`default_nettype wire
